// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/sfdr_pkg.sv =====
package sfdr_pkg;

	localparam int unsigned MAX_FRAME_DEF = 400;
	localparam int unsigned MIN_ROUTED    = 4;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

	localparam logic [7:0]  DELIMITER_RST  = 8'd126;
	localparam logic [15:0] LOCAL_ADDR_RST = 16'd1;
	localparam logic [8:0]  MAX_LENGTH_RST = 9'd400;

	localparam logic [15:0] ADDR_NONE = 16'h0000;
	localparam logic [15:0] ADDR_ALL  = 16'hFFFF;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	typedef struct packed {
		logic [7:0]  delimiter_byte;
		logic [15:0] local_address;
		logic [8:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [8:0] byte_index;
		logic       frame_last;
		logic       deliver_local;
		logic       forward_out;
		logic       too_short;
	} result_t;

endpackage

// ===== hw/rtl/sfdr_parser.sv =====
module sfdr_parser
	import sfdr_pkg::*;
#(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA
	} phase_t;

	localparam logic [8:0] MAX_LIM = 9'(MAX_FRAME);
	localparam logic [8:0] MIN_LEN = 9'(MIN_ROUTED);

	phase_t      phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [8:0]  expected_q, expected_d;
	logic [8:0]  count_q, count_d;
	logic [15:0] addr_q, addr_d;

	logic [8:0]  limit;
	logic [15:0] len_full;
	logic [8:0]  count_inc;

	assign limit     = (cfg.max_length < MAX_LIM) ? cfg.max_length : MAX_LIM;
	assign len_full  = {len_hi_q, rx_byte};
	assign count_inc = count_q + 9'd1;

	always_comb begin
		res        = '0;
		phase_d    = phase_q;
		len_hi_d   = len_hi_q;
		expected_d = expected_q;
		count_d    = count_q;
		addr_d     = addr_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.delimiter_byte) begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				len_hi_d = rx_byte;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len_full == 16'd0 || len_full > {7'd0, limit}) begin
					res.kind   = KIND_REJECT;
					expected_d = '0;
					phase_d    = PH_HUNT;
				end else begin
					expected_d = len_full[8:0];
					count_d    = '0;
					phase_d    = PH_DATA;
				end
			end
			PH_DATA: begin
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
				if (count_q == 9'd0) begin
					addr_d = {rx_byte, 8'd0};
				end else if (count_q == 9'd1) begin
					addr_d = {addr_q[15:8], rx_byte};
				end
				count_d = count_inc;
				if (count_inc == expected_q) begin
					res.frame_last = 1'b1;
					if (count_inc < MIN_LEN) begin
						res.too_short = 1'b1;
					end else if (addr_d == ADDR_NONE || addr_d == ADDR_ALL) begin
						res.deliver_local = 1'b1;
						res.forward_out   = 1'b1;
					end else if (addr_d == cfg.local_address) begin
						res.deliver_local = 1'b1;
					end else begin
						res.forward_out = 1'b1;
					end
					phase_d = PH_HUNT;
					count_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			len_hi_q   <= '0;
			expected_q <= '0;
			count_q    <= '0;
			addr_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			len_hi_q   <= len_hi_d;
			expected_q <= expected_d;
			count_q    <= count_d;
			addr_q     <= addr_d;
		end
	end

endmodule

// ===== hw/rtl/sfdr_out_skid.sv =====
`include "assert_macros.svh"

module sfdr_out_skid
	import sfdr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    accept;
	logic    drain;

	assign in_ready  = !skid_v_q;
	assign accept    = in_valid && in_ready;
	assign drain     = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_v_q ? skid_q : in_res;
		end
		if (!drain && accept) begin
			skid_q <= in_res;
		end
	end

	`ASSERT_NEVER(a_skid_needs_out, clk, arst_n, skid_v_q && !out_v_q)
	`ASSERT_CLK(a_stall_fills_skid, clk, arst_n, accept && out_v_q && !out_ready |=> skid_v_q)
	`ASSERT_CLK(a_skid_moves_out, clk, arst_n, skid_v_q && out_ready |=> out_v_q && !skid_v_q)

endmodule

// ===== hw/rtl/serial_frame_deframer_router.sv =====
// Serial frame parser: each input beat carries one line byte and yields exactly one result
// beat. The parser hunts for the delimiter, reads a big-endian 16-bit length, passes the
// payload bytes with their index and, on the last byte, routes the frame by its first two
// bytes (broadcast, local or forward) or flags it as too short, and rejects a zero or
// over-limit length. One beat is taken every cycle while input ready is high; the parser
// state updates as the beat is taken and the result is registered at the output. A skid
// stage behind it lets one more beat in while a result is stalled; input ready drops only
// while that stage is full. Register writes take effect at the next beat.
module serial_frame_deframer_router
	import sfdr_pkg::*;
#(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [7:0]            payload_byte,
	output logic [8:0]            byte_index,
	output logic                  frame_last,
	output logic                  deliver_local,
	output logic                  forward_out,
	output logic                  too_short
);

	cfg_t    cfg_q;
	result_t parse_res;
	result_t out_res;
	logic    accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_byte <= DELIMITER_RST;
			cfg_q.local_address  <= LOCAL_ADDR_RST;
			cfg_q.max_length     <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELIMITER:  cfg_q.delimiter_byte <= cfg_wdata[7:0];
				CFG_LOCAL_ADDR: cfg_q.local_address  <= cfg_wdata[15:0];
				CFG_MAX_LENGTH: cfg_q.max_length     <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	sfdr_parser #(
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(rx_byte),
		.cfg    (cfg_q),
		.res    (parse_res)
	);

	sfdr_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_res   (parse_res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign kind          = out_res.kind;
	assign payload_byte  = out_res.payload_byte;
	assign byte_index    = out_res.byte_index;
	assign frame_last    = out_res.frame_last;
	assign deliver_local = out_res.deliver_local;
	assign forward_out   = out_res.forward_out;
	assign too_short     = out_res.too_short;

endmodule
